// File: hw/rtl/ksit_pkg.sv
// ----------------------------------------------------------------------------
// ksit_pkg
// Shared constants and controller/datapath command and status types for the
// key sorter with index tags.
// ----------------------------------------------------------------------------
package ksit_pkg;

  localparam int CAPACITY_DEFAULT = 64;
  localparam int KEY_BITS_DEFAULT = 32;
  localparam int PORT_KEY_W       = 32;
  localparam int TAG_W            = 6;

  typedef struct packed {
    logic accept;      // latch the request key and tag
    logic write_port;  // write the request key straight to entry zero
    logic write_ins;   // write the held key at the current slot
    logic write_shift; // move the read entry up one slot
    logic dec_slot;
    logic inc_fill;
    logic set_dropped;
    logic rd_sort;
    logic rd_emit;
    logic load_out;
    logic out_taken;
    logic inc_emit;
    logic clear_batch;
  } ksit_cmd_t;

  typedef struct packed {
    logic full;
    logic fill_zero;
    logic greater;
    logic slot_one;
    logic emit_last;
  } ksit_status_t;

endpackage

// File: hw/rtl/key_sorter_with_index_tags_core.sv
// ----------------------------------------------------------------------------
// key_sorter_with_index_tags_core
// Batch sorter: collects tagged keys, emits them in ascending key order.
// ----------------------------------------------------------------------------
// Input channel (in_valid, in_stall, key, last): one key per request. Each
// stored key is tagged with its arrival position. Keys past CAPACITY are
// dropped and flag overflow on every result of the batch. A request with
// last high closes the batch.
// Keys are placed in order as they arrive, by insertion into one memory
// with one write and one registered read port: a request into an empty
// batch is written straight to entry zero, one into a full batch is
// dropped; else each stored key larger than it, read from the top down,
// moves up one slot, and in_stall stays high until the key is placed.
// Output channel (out_valid, out_stall, sorted_key, source_index, overflow,
// last_out): after the closing request, one result per stored key in
// ascending order (equal keys in arrival order), last_out on the final one.
// Each result is read from memory, then loaded into the output register;
// the next read waits until the pending result is taken. A stalled result
// holds its payload; no request is taken until the batch is drained.
// Reset (rst, synchronous) empties the batch and drops any pending result.
// ----------------------------------------------------------------------------
module key_sorter_with_index_tags_core #(
  parameter int CAPACITY = ksit_pkg::CAPACITY_DEFAULT,
  parameter int KEY_BITS = ksit_pkg::KEY_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ksit_pkg::PORT_KEY_W-1:0] key,
  input  logic                            last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ksit_pkg::PORT_KEY_W-1:0] sorted_key,
  output logic [ksit_pkg::TAG_W-1:0]      source_index,
  output logic                            overflow,
  output logic                            last_out
);

  ksit_pkg::ksit_cmd_t    cmd;
  ksit_pkg::ksit_status_t status;

  ksit_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ksit_datapath #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .key          (key),
    .out_valid    (out_valid),
    .sorted_key   (sorted_key),
    .source_index (source_index),
    .overflow     (overflow),
    .last_out     (last_out)
  );

endmodule

// File: hw/rtl/ksit_datapath.sv
// ----------------------------------------------------------------------------
// ksit_datapath
// Entry memory (key and tag), insertion registers, fill and emit counters,
// and the result output register.
// ----------------------------------------------------------------------------
module ksit_datapath #(
  parameter int CAPACITY = ksit_pkg::CAPACITY_DEFAULT,
  parameter int KEY_BITS = ksit_pkg::KEY_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ksit_pkg::ksit_cmd_t               cmd,
  output ksit_pkg::ksit_status_t            status,
  input  logic [ksit_pkg::PORT_KEY_W-1:0]   key,
  output logic                              out_valid,
  output logic [ksit_pkg::PORT_KEY_W-1:0]   sorted_key,
  output logic [ksit_pkg::TAG_W-1:0]        source_index,
  output logic                              overflow,
  output logic                              last_out
);

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int ENTRY_W = KEY_BITS + ksit_pkg::TAG_W;

  logic [ENTRY_W-1:0] mem [CAPACITY];
  logic [ENTRY_W-1:0] rd_data;

  logic [KEY_BITS-1:0]        ins_key;
  logic [ksit_pkg::TAG_W-1:0] ins_tag;
  logic [IDX_W-1:0]           slot;
  logic [IDX_W-1:0]           emit;
  logic [CNT_W-1:0]           fill;
  logic                       dropped;

  logic [KEY_BITS-1:0]        out_key;
  logic [ksit_pkg::TAG_W-1:0] out_tag;

  logic [KEY_BITS-1:0]        port_key;
  logic [ksit_pkg::TAG_W-1:0] port_tag;
  logic                       we;
  logic [IDX_W-1:0]           waddr;
  logic [ENTRY_W-1:0]         wdata;
  logic                       re;
  logic [IDX_W-1:0]           raddr;

  assign port_key = key[KEY_BITS-1:0];
  assign port_tag = ksit_pkg::TAG_W'(fill);

  always_comb begin
    we    = cmd.write_port | cmd.write_ins | cmd.write_shift;
    waddr = cmd.write_port ? '0 : slot;
    if (cmd.write_port) begin
      wdata = {port_key, port_tag};
    end else if (cmd.write_shift) begin
      wdata = rd_data;
    end else begin
      wdata = {ins_key, ins_tag};
    end
    re    = cmd.rd_sort | cmd.rd_emit;
    raddr = cmd.rd_sort ? slot - IDX_W'(1) : emit;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ins_key <= port_key;
      ins_tag <= port_tag;
    end
    if (cmd.load_out) begin
      out_key  <= rd_data[ENTRY_W-1:ksit_pkg::TAG_W];
      out_tag  <= rd_data[ksit_pkg::TAG_W-1:0];
      overflow <= dropped;
      last_out <= status.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot      <= '0;
      emit      <= '0;
      fill      <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        slot <= fill[IDX_W-1:0];
      end else if (cmd.dec_slot) begin
        slot <= slot - IDX_W'(1);
      end
      if (cmd.clear_batch) begin
        fill    <= '0;
        dropped <= 1'b0;
        emit    <= '0;
      end else begin
        if (cmd.inc_fill) begin
          fill <= fill + CNT_W'(1);
        end
        if (cmd.set_dropped) begin
          dropped <= 1'b1;
        end
        if (cmd.inc_emit) begin
          emit <= emit + IDX_W'(1);
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (cmd.out_taken) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    status.full      = (fill == CNT_W'(CAPACITY));
    status.fill_zero = (fill == '0);
    status.greater   = (rd_data[ENTRY_W-1:ksit_pkg::TAG_W] > ins_key);
    status.slot_one  = (slot == IDX_W'(1));
    status.emit_last = ((CNT_W'(emit) + CNT_W'(1)) == fill);
  end

  assign sorted_key   = ksit_pkg::PORT_KEY_W'(out_key);
  assign source_index = out_tag;

endmodule

// File: hw/rtl/ksit_ctrl.sv
// ----------------------------------------------------------------------------
// ksit_ctrl
// Sequencer for loading with insertion, and for emitting the sorted batch.
// ----------------------------------------------------------------------------
module ksit_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   last,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  ksit_pkg::ksit_status_t status,
  output ksit_pkg::ksit_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_READ    = 6'b000010,
    S_COMPARE = 6'b000100,
    S_PUT     = 6'b001000,
    S_EMIT_RD = 6'b010000,
    S_EMIT_LD = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   close_pending;
  logic   close_pending_next;
  logic   done_next_state;

  always_comb begin
    cmd                = '0;
    state_next         = state;
    close_pending_next = close_pending;
    in_stall           = (state != S_IDLE);
    done_next_state    = close_pending;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          close_pending_next = last;
          if (status.full) begin
            cmd.set_dropped = 1'b1;
            if (last) begin
              state_next = S_EMIT_RD;
            end
          end else begin
            cmd.accept   = 1'b1;
            cmd.inc_fill = 1'b1;
            if (status.fill_zero) begin
              cmd.write_port = 1'b1;
              if (last) begin
                state_next = S_EMIT_RD;
              end
            end else begin
              state_next = S_READ;
            end
          end
        end
      end
      S_READ: begin
        cmd.rd_sort = 1'b1;
        state_next  = S_COMPARE;
      end
      S_COMPARE: begin
        if (status.greater) begin
          cmd.write_shift = 1'b1;
          cmd.dec_slot    = 1'b1;
          state_next      = status.slot_one ? S_PUT : S_READ;
        end else begin
          cmd.write_ins = 1'b1;
          state_next    = done_next_state ? S_EMIT_RD : S_IDLE;
        end
      end
      S_PUT: begin
        cmd.write_ins = 1'b1;
        state_next    = done_next_state ? S_EMIT_RD : S_IDLE;
      end
      S_EMIT_RD: begin
        if (!out_valid) begin
          cmd.rd_emit = 1'b1;
          state_next  = S_EMIT_LD;
        end else if (!out_stall) begin
          // hold the next read until the pending result is taken
          cmd.out_taken = 1'b1;
          cmd.rd_emit   = 1'b1;
          state_next    = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        cmd.load_out = 1'b1;
        if (status.emit_last) begin
          cmd.clear_batch    = 1'b1;
          close_pending_next = 1'b0;
          state_next         = S_IDLE;
        end else begin
          cmd.inc_emit = 1'b1;
          state_next   = S_EMIT_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // retire the final result once the batch has closed
    if (state != S_EMIT_RD && state != S_EMIT_LD && out_valid && !out_stall) begin
      cmd.out_taken = 1'b1;
    end
    if (state != S_EMIT_RD && state != S_EMIT_LD && out_valid) begin
      in_stall = 1'b1;
      if (state == S_IDLE) begin
        cmd                = '0;
        cmd.out_taken      = !out_stall;
        state_next         = S_IDLE;
        close_pending_next = close_pending;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      close_pending <= 1'b0;
    end else begin
      state         <= state_next;
      close_pending <= close_pending_next;
    end
  end

endmodule
